// ===== hw/rtl/stt_pkg.sv =====
`default_nettype none
package stt_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_WORD,
		MODE_NUMBER,
		MODE_STRING,
		MODE_COMMENT,
		MODE_OPERATOR
	} mode_t;

	typedef enum logic [2:0] {
		OP_EQ,
		OP_PLUS,
		OP_LT,
		OP_GT,
		OP_BANG,
		OP_SLASH
	} op_t;

	localparam logic [5:0] K_EQ       = 6'd12;
	localparam logic [5:0] K_EQEQ     = 6'd13;
	localparam logic [5:0] K_PLUS     = 6'd14;
	localparam logic [5:0] K_PLUSPLUS = 6'd15;
	localparam logic [5:0] K_MINUS    = 6'd16;
	localparam logic [5:0] K_STAR     = 6'd17;
	localparam logic [5:0] K_SLASH    = 6'd18;
	localparam logic [5:0] K_PERCENT  = 6'd19;
	localparam logic [5:0] K_LT       = 6'd20;
	localparam logic [5:0] K_LE       = 6'd21;
	localparam logic [5:0] K_GT       = 6'd22;
	localparam logic [5:0] K_GE       = 6'd23;
	localparam logic [5:0] K_NE       = 6'd24;
	localparam logic [5:0] K_SHL      = 6'd25;
	localparam logic [5:0] K_LPAREN   = 6'd26;
	localparam logic [5:0] K_RPAREN   = 6'd27;
	localparam logic [5:0] K_LBRACE   = 6'd28;
	localparam logic [5:0] K_RBRACE   = 6'd29;
	localparam logic [5:0] K_SEMI     = 6'd30;
	localparam logic [5:0] K_IDENT    = 6'd9;
	localparam logic [5:0] K_NUMBER   = 6'd10;
	localparam logic [5:0] K_STRING   = 6'd11;
	localparam logic [5:0] K_EOF      = 6'd31;
	localparam logic [5:0] K_UNKNOWN  = 6'd32;

	localparam int NUM_KW = 9;
	localparam logic [39:0] KW_TEXT [NUM_KW] = '{
		40'h00_00746e69,
		40'h74_616f6c66,
		40'h00_00006669,
		40'h00_65736c65,
		40'h00_00726f66,
		40'h65_6c696877,
		40'h00_74756f63,
		40'h00_6c646e65,
		40'h00_6e69616d
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{
		3'd3, 3'd5, 3'd2, 3'd4, 3'd3, 3'd5, 3'd4, 3'd4, 3'd4
	};

	localparam int FIFO_AW    = 2;
	localparam int FIFO_DEPTH = 1 << FIFO_AW;
	localparam int CNT_W      = FIFO_AW + 1;

	typedef struct packed {
		logic [5:0]  kind;
		logic [31:0] start;
		logic [31:0] len;
		logic        last;
	} tok_t;

	function automatic logic is_space(input logic [7:0] c);
		return c inside {[8'd9:8'd13], 8'd32};
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return c inside {["A":"Z"], ["a":"z"]};
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {["0":"9"]};
	endfunction

	function automatic logic is_op_start(input logic [7:0] c);
		return c inside {"=", "+", "<", ">", "!", "/"};
	endfunction

	function automatic op_t op_code(input logic [7:0] c);
		op_t op;
		case (c)
			"+":     op = OP_PLUS;
			"<":     op = OP_LT;
			">":     op = OP_GT;
			"!":     op = OP_BANG;
			"/":     op = OP_SLASH;
			default: op = OP_EQ;
		endcase
		return op;
	endfunction

	function automatic logic [5:0] byte_kind(input logic [7:0] c);
		logic [5:0] k;
		case (c)
			"-":     k = K_MINUS;
			"*":     k = K_STAR;
			"%":     k = K_PERCENT;
			"(":     k = K_LPAREN;
			")":     k = K_RPAREN;
			"{":     k = K_LBRACE;
			"}":     k = K_RBRACE;
			";":     k = K_SEMI;
			default: k = K_UNKNOWN;
		endcase
		return k;
	endfunction

	function automatic logic [5:0] single_kind(input op_t op);
		logic [5:0] k;
		case (op)
			OP_EQ:    k = K_EQ;
			OP_PLUS:  k = K_PLUS;
			OP_LT:    k = K_LT;
			OP_GT:    k = K_GT;
			OP_SLASH: k = K_SLASH;
			default:  k = K_UNKNOWN;
		endcase
		return k;
	endfunction

	// zero when the byte does not complete a two-byte operator
	function automatic logic [5:0] pair_kind(input op_t op, input logic [7:0] c);
		logic [5:0] k;
		k = 6'd0;
		case (op)
			OP_EQ:   if (c == "=") k = K_EQEQ;
			OP_PLUS: if (c == "+") k = K_PLUSPLUS;
			OP_LT: begin
				if (c == "<") k = K_SHL;
				else if (c == "=") k = K_LE;
			end
			OP_GT:   if (c == "=") k = K_GE;
			OP_BANG: if (c == "=") k = K_NE;
			default: k = 6'd0;
		endcase
		return k;
	endfunction

	function automatic logic [5:0] word_kind(input logic [39:0] prefix, input logic [2:0] len);
		logic [5:0] k;
		k = K_IDENT;
		for (int i = 0; i < NUM_KW; i++) begin
			if (KW_LEN[i] == len && KW_TEXT[i] == prefix)
				k = 6'(i);
		end
		return k;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/source_text_tokenizer_top.sv =====
// Pipeline: a byte is registered on acceptance and scanned into the 4-entry result
// queue once that queue has room for two tokens. Throughput: one byte per cycle
// while the queue has room; the output gives one token per cycle while tok_stall is
// low; a byte that closes a token and opens another (two tokens) gives both in turn.
// Reset: arst_n low clears scan state, offset counter and queue; no token pending.
`default_nettype none
module source_text_tokenizer_top #(
	parameter int OFFSET_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        src_valid,
	output logic             src_stall,
	input  wire logic [7:0]  ch,
	input  wire logic        end_of_text,
	output logic             tok_valid,
	input  wire logic        tok_stall,
	output logic [5:0]       token_kind,
	output logic [31:0]      start_offset,
	output logic [31:0]      text_length,
	output logic             last
);

	logic                 vld_s1;
	logic [7:0]           ch_s1;
	logic                 eot_s1;

	stt_pkg::mode_t       mode_q, mode_d;
	stt_pkg::op_t         pend_q, pend_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d;
	logic [OFFSET_BITS-1:0] tb_q, tb_d;
	logic [OFFSET_BITS-1:0] span;
	logic                 sp_q, sp_d;
	logic [39:0]          kp_q, kp_d;
	logic [2:0]           wl_q, wl_d;

	stt_pkg::tok_t        mem [stt_pkg::FIFO_DEPTH];
	logic [stt_pkg::FIFO_AW-1:0] wr_q, rd_q;
	logic [stt_pkg::CNT_W-1:0]   cnt_q;

	logic adv, src_acc, pop;

	logic flush_en, disp_en, word_cont, set_point, two_op, to_comment, to_idle;
	logic word_ch;
	logic [5:0] k2;

	stt_pkg::tok_t tok_a, tok_b;
	logic a_vld, b_vld;
	logic [stt_pkg::CNT_W-1:0] push_n;

	assign adv       = vld_s1 && (cnt_q <= stt_pkg::CNT_W'(stt_pkg::FIFO_DEPTH - 2));
	assign src_stall = vld_s1 && !adv;
	assign src_acc   = src_valid && !src_stall;
	assign tok_valid = cnt_q != '0;
	assign pop       = tok_valid && !tok_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (src_acc) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_acc) begin
			ch_s1  <= ch;
			eot_s1 <= end_of_text;
		end
	end

	assign word_ch = stt_pkg::is_alpha(ch_s1) || stt_pkg::is_digit(ch_s1) || ch_s1 == "_";
	assign k2      = stt_pkg::pair_kind(pend_q, ch_s1);
	assign span    = pos_q - tb_q;

	always_comb begin
		flush_en   = 1'b0;
		disp_en    = 1'b0;
		word_cont  = 1'b0;
		set_point  = 1'b0;
		two_op     = 1'b0;
		to_comment = 1'b0;
		to_idle    = 1'b0;
		if (eot_s1) begin
			flush_en = 1'b1;
		end else begin
			case (mode_q)
				stt_pkg::MODE_WORD: begin
					if (word_ch) begin
						word_cont = 1'b1;
					end else begin
						flush_en = 1'b1;
						disp_en  = 1'b1;
					end
				end
				stt_pkg::MODE_NUMBER: begin
					if (stt_pkg::is_digit(ch_s1)) begin
						flush_en = 1'b0;
					end else if (ch_s1 == "." && !sp_q) begin
						set_point = 1'b1;
					end else begin
						flush_en = 1'b1;
						disp_en  = 1'b1;
					end
				end
				stt_pkg::MODE_STRING: begin
					flush_en = ch_s1 == "\"";
				end
				stt_pkg::MODE_COMMENT: begin
					to_idle = ch_s1 == 8'h0a;
				end
				stt_pkg::MODE_OPERATOR: begin
					if (k2 != 6'd0) begin
						two_op = 1'b1;
					end else if (pend_q == stt_pkg::OP_SLASH && ch_s1 == "/") begin
						to_comment = 1'b1;
					end else begin
						flush_en = 1'b1;
						disp_en  = 1'b1;
					end
				end
				default: begin
					disp_en = 1'b1;
				end
			endcase
		end
	end

	// next scan state
	always_comb begin
		mode_d = mode_q;
		pend_d = pend_q;
		pos_d  = pos_q + OFFSET_BITS'(1);
		tb_d   = tb_q;
		sp_d   = sp_q;
		kp_d   = kp_q;
		wl_d   = wl_q;
		if (eot_s1) begin
			mode_d = stt_pkg::MODE_IDLE;
			pend_d = stt_pkg::OP_EQ;
			pos_d  = '0;
			tb_d   = '0;
			sp_d   = 1'b0;
			kp_d   = '0;
			wl_d   = '0;
		end else begin
			if (flush_en || to_idle || two_op || disp_en)
				mode_d = stt_pkg::MODE_IDLE;
			if (to_comment)
				mode_d = stt_pkg::MODE_COMMENT;
			if (set_point)
				sp_d = 1'b1;
			if (word_cont) begin
				if (wl_q < 3'd5)
					kp_d[{wl_q, 3'b000} +: 8] = ch_s1;
				if (wl_q < 3'd6)
					wl_d = wl_q + 3'd1;
			end
			if (disp_en) begin
				if (stt_pkg::is_space(ch_s1)) begin
					mode_d = stt_pkg::MODE_IDLE;
				end else if (stt_pkg::is_alpha(ch_s1) || ch_s1 == "_") begin
					mode_d = stt_pkg::MODE_WORD;
					tb_d   = pos_q;
					kp_d   = {32'd0, ch_s1};
					wl_d   = 3'd1;
				end else if (stt_pkg::is_digit(ch_s1)) begin
					mode_d = stt_pkg::MODE_NUMBER;
					tb_d   = pos_q;
					sp_d   = 1'b0;
				end else if (ch_s1 == "\"") begin
					mode_d = stt_pkg::MODE_STRING;
					tb_d   = pos_q + OFFSET_BITS'(1);
				end else if (stt_pkg::is_op_start(ch_s1)) begin
					mode_d = stt_pkg::MODE_OPERATOR;
					pend_d = stt_pkg::op_code(ch_s1);
					tb_d   = pos_q;
				end
			end
		end
	end

	// tokens of this byte: closed token first, then the new one
	always_comb begin
		a_vld      = flush_en && mode_q != stt_pkg::MODE_IDLE && mode_q != stt_pkg::MODE_COMMENT;
		tok_a.start = 32'(tb_q);
		tok_a.len   = 32'(span);
		tok_a.last  = 1'b0;
		case (mode_q)
			stt_pkg::MODE_WORD:   tok_a.kind = stt_pkg::word_kind(kp_q, wl_q);
			stt_pkg::MODE_NUMBER: tok_a.kind = stt_pkg::K_NUMBER;
			stt_pkg::MODE_STRING: tok_a.kind = stt_pkg::K_STRING;
			stt_pkg::MODE_OPERATOR: begin
				tok_a.kind = stt_pkg::single_kind(pend_q);
				tok_a.len  = 32'(OFFSET_BITS'(1));
			end
			default: tok_a.kind = stt_pkg::K_UNKNOWN;
		endcase

		b_vld       = 1'b0;
		tok_b.kind  = stt_pkg::byte_kind(ch_s1);
		tok_b.start = 32'(pos_q);
		tok_b.len   = 32'd1;
		tok_b.last  = 1'b1;
		if (eot_s1) begin
			b_vld      = 1'b1;
			tok_b.kind = stt_pkg::K_EOF;
			tok_b.len  = 32'd0;
		end else if (two_op) begin
			b_vld       = 1'b1;
			tok_b.kind  = k2;
			tok_b.start = 32'(tb_q);
			tok_b.len   = 32'd2;
		end else if (disp_en) begin
			b_vld = !stt_pkg::is_space(ch_s1) && !word_ch && ch_s1 != "\""
				&& !stt_pkg::is_op_start(ch_s1);
		end
		if (!b_vld)
			tok_a.last = 1'b1;
		push_n = adv ? (stt_pkg::CNT_W'(a_vld) + stt_pkg::CNT_W'(b_vld)) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stt_pkg::MODE_IDLE;
			pend_q <= stt_pkg::OP_EQ;
			pos_q  <= '0;
			tb_q   <= '0;
			sp_q   <= 1'b0;
			kp_q   <= '0;
			wl_q   <= '0;
		end else if (adv) begin
			mode_q <= mode_d;
			pend_q <= pend_d;
			pos_q  <= pos_d;
			tb_q   <= tb_d;
			sp_q   <= sp_d;
			kp_q   <= kp_d;
			wl_q   <= wl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (a_vld && b_vld) begin
				mem[wr_q] <= tok_a;
				mem[stt_pkg::FIFO_AW'(wr_q + 1'b1)] <= tok_b;
			end else if (a_vld) begin
				mem[wr_q] <= tok_a;
			end else if (b_vld) begin
				mem[wr_q] <= tok_b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= stt_pkg::FIFO_AW'(wr_q + push_n);
			if (pop)
				rd_q <= stt_pkg::FIFO_AW'(rd_q + 1'b1);
			cnt_q <= cnt_q + push_n - stt_pkg::CNT_W'(pop);
		end
	end

	assign token_kind   = mem[rd_q].kind;
	assign start_offset = mem[rd_q].start;
	assign text_length  = mem[rd_q].len;
	assign last         = mem[rd_q].last;

endmodule
`default_nettype wire

// ===== hw/rtl/stt_checker.sv =====
`default_nettype none
module stt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        src_valid,
	input wire logic        src_stall,
	input wire logic [7:0]  ch,
	input wire logic        end_of_text,
	input wire logic        tok_valid,
	input wire logic        tok_stall,
	input wire logic [5:0]  token_kind,
	input wire logic [31:0] start_offset,
	input wire logic [31:0] text_length,
	input wire logic        last
);

	a_src_hold: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_stall |=> src_valid && $stable(ch) && $stable(end_of_text))
		else $error("input item changed while stalled");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_stall |=> tok_valid && $stable(token_kind)
			&& $stable(start_offset) && $stable(text_length) && $stable(last))
		else $error("item changed while stalled");

	a_eof: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && token_kind == stt_pkg::K_EOF |-> text_length == 32'd0 && last)
		else $error("end-of-file item malformed");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> token_kind <= stt_pkg::K_UNKNOWN)
		else $error("kind out of range");

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (token_kind == stt_pkg::K_EQEQ || token_kind == stt_pkg::K_PLUSPLUS
			|| token_kind == stt_pkg::K_LE || token_kind == stt_pkg::K_GE
			|| token_kind == stt_pkg::K_NE || token_kind == stt_pkg::K_SHL)
			|-> text_length == 32'd2 && last)
		else $error("two-byte operator length wrong");

endmodule

bind source_text_tokenizer_top stt_checker u_stt_checker (.*);
`default_nettype wire

// ===== verif/tb_token_checker.sv =====
`timescale 1ns / 1ps

module tb_token_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	input  logic        src_stall,
	input  logic [7:0]  ch,
	input  logic        end_of_text,
	input  logic        tok_valid,
	input  logic        tok_stall,
	input  logic [5:0]  token_kind,
	input  logic [31:0] start_offset,
	input  logic [31:0] text_length,
	input  logic        last,
	output int          fails,
	output int          outstanding
);
	import stt_pkg::*;

	localparam logic [5:0] KW_INT   = 6'd0;
	localparam logic [5:0] KW_FLOAT = 6'd1;
	localparam logic [5:0] KW_IF    = 6'd2;
	localparam logic [5:0] KW_ELSE  = 6'd3;
	localparam logic [5:0] KW_FOR   = 6'd4;
	localparam logic [5:0] KW_WHILE = 6'd5;
	localparam logic [5:0] KW_COUT  = 6'd6;
	localparam logic [5:0] KW_ENDL  = 6'd7;
	localparam logic [5:0] KW_MAIN  = 6'd8;
	localparam logic [5:0] NO_PAIR  = 6'd0;

	mode_t       scan_mode;
	op_t         held_op;
	logic [31:0] offset;
	logic [31:0] tok_begin;
	logic        point_seen;
	logic [39:0] word_text;
	logic [2:0]  word_len;
	tok_t        expect_q[$];
	int          made;
	int          mism = 0;

	function automatic logic blank_char(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic letter_char(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic digit_char(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic word_char(input logic [7:0] c);
		return letter_char(c) || digit_char(c) || c == "_";
	endfunction

	// word_text holds the first five bytes, first byte most significant
	function automatic logic [5:0] keyword_code(input logic [39:0] w, input logic [2:0] n);
		logic [5:0] k;
		k = K_IDENT;
		if (n <= 3'd5) begin
			case (w)
				"int":   k = KW_INT;
				"float": k = KW_FLOAT;
				"if":    k = KW_IF;
				"else":  k = KW_ELSE;
				"for":   k = KW_FOR;
				"while": k = KW_WHILE;
				"cout":  k = KW_COUT;
				"endl":  k = KW_ENDL;
				"main":  k = KW_MAIN;
				default: k = K_IDENT;
			endcase
		end
		return k;
	endfunction

	function automatic logic [5:0] lone_op_kind(input op_t op);
		case (op)
			OP_EQ:    return K_EQ;
			OP_PLUS:  return K_PLUS;
			OP_LT:    return K_LT;
			OP_GT:    return K_GT;
			OP_SLASH: return K_SLASH;
			default:  return K_UNKNOWN;
		endcase
	endfunction

	function automatic logic [5:0] two_byte_kind(input op_t op, input logic [7:0] c);
		if (op == OP_EQ && c == "=") return K_EQEQ;
		if (op == OP_PLUS && c == "+") return K_PLUSPLUS;
		if (op == OP_LT && c == "<") return K_SHL;
		if (op == OP_LT && c == "=") return K_LE;
		if (op == OP_GT && c == "=") return K_GE;
		if (op == OP_BANG && c == "=") return K_NE;
		return NO_PAIR;
	endfunction

	function automatic logic [5:0] punct_kind(input logic [7:0] c);
		case (c)
			"-":     return K_MINUS;
			"*":     return K_STAR;
			"%":     return K_PERCENT;
			"(":     return K_LPAREN;
			")":     return K_RPAREN;
			"{":     return K_LBRACE;
			"}":     return K_RBRACE;
			";":     return K_SEMI;
			default: return K_UNKNOWN;
		endcase
	endfunction

	task automatic clear_scan();
		scan_mode  = MODE_IDLE;
		held_op    = OP_EQ;
		offset     = '0;
		tok_begin  = '0;
		point_seen = 1'b0;
		word_text  = '0;
		word_len   = '0;
	endtask

	task automatic push_token(input logic [5:0] kind, input logic [31:0] start,
			input logic [31:0] len);
		tok_t t;
		t.kind  = kind;
		t.start = start;
		t.len   = len;
		t.last  = 1'b0;
		expect_q.insert(expect_q.size(), t);
		made++;
	endtask

	task automatic close_token();
		case (scan_mode)
			MODE_WORD:     push_token(keyword_code(word_text, word_len), tok_begin,
					offset - tok_begin);
			MODE_NUMBER:   push_token(K_NUMBER, tok_begin, offset - tok_begin);
			MODE_STRING:   push_token(K_STRING, tok_begin, offset - tok_begin);
			MODE_OPERATOR: push_token(lone_op_kind(held_op), tok_begin, 32'd1);
			default: ;
		endcase
		scan_mode = MODE_IDLE;
	endtask

	task automatic open_token(input logic [7:0] c);
		if (blank_char(c)) begin
		end else if (letter_char(c) || c == "_") begin
			scan_mode = MODE_WORD;
			tok_begin = offset;
			word_text = {32'd0, c};
			word_len  = 3'd1;
		end else if (digit_char(c)) begin
			scan_mode  = MODE_NUMBER;
			tok_begin  = offset;
			point_seen = 1'b0;
		end else if (c == "\"") begin
			scan_mode = MODE_STRING;
			tok_begin = offset + 32'd1;
		end else if (c == "=" || c == "+" || c == "<" || c == ">" || c == "!" || c == "/") begin
			case (c)
				"=":     held_op = OP_EQ;
				"+":     held_op = OP_PLUS;
				"<":     held_op = OP_LT;
				">":     held_op = OP_GT;
				"!":     held_op = OP_BANG;
				default: held_op = OP_SLASH;
			endcase
			scan_mode = MODE_OPERATOR;
			tok_begin = offset;
		end else begin
			push_token(punct_kind(c), offset, 32'd1);
		end
	endtask

	task automatic scan_item(input logic [7:0] c, input logic eot);
		logic [5:0] pair;
		tok_t       t;
		made = 0;
		if (eot) begin
			close_token();
			push_token(K_EOF, offset, 32'd0);
			clear_scan();
		end else begin
			case (scan_mode)
				MODE_WORD: begin
					if (word_char(c)) begin
						if (word_len < 3'd5) word_text = {word_text[31:0], c};
						if (word_len < 3'd6) word_len = word_len + 3'd1;
					end else begin
						close_token();
						open_token(c);
					end
				end
				MODE_NUMBER: begin
					if (digit_char(c)) begin
					end else if (c == "." && !point_seen) begin
						point_seen = 1'b1;
					end else begin
						close_token();
						open_token(c);
					end
				end
				MODE_STRING: begin
					if (c == "\"") close_token();
				end
				MODE_COMMENT: begin
					if (c == "\n") scan_mode = MODE_IDLE;
				end
				MODE_OPERATOR: begin
					pair = two_byte_kind(held_op, c);
					if (pair != NO_PAIR) begin
						push_token(pair, tok_begin, 32'd2);
						scan_mode = MODE_IDLE;
					end else if (held_op == OP_SLASH && c == "/") begin
						scan_mode = MODE_COMMENT;
					end else begin
						close_token();
						open_token(c);
					end
				end
				default: begin
					scan_mode = MODE_IDLE;
					open_token(c);
				end
			endcase
			offset = offset + 32'd1;
		end
		if (made != 0) begin
			t = expect_q.pop_back();
			t.last = 1'b1;
			expect_q.insert(expect_q.size(), t);
		end
	endtask

	task automatic check_token();
		tok_t want;
		if (expect_q.size() == 0) begin
			mism++;
			if (mism <= 10)
				$display("unexpected token: kind %0d start %0d len %0d last %0d",
					token_kind, start_offset, text_length, last);
		end else begin
			want = expect_q.pop_front();
			if (token_kind !== want.kind || start_offset !== want.start ||
					text_length !== want.len || last !== want.last) begin
				mism++;
				if (mism <= 10)
					$display("token mismatch: expected kind %0d start %0d len %0d last %0d,",
						want.kind, want.start, want.len, want.last,
						" got kind %0d start %0d len %0d last %0d",
						token_kind, start_offset, text_length, last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			expect_q.delete();
			outstanding <= 0;
			fails <= mism;
		end else begin
			if (src_valid && !src_stall) scan_item(ch, end_of_text);
			if (tok_valid && !tok_stall) check_token();
			outstanding <= expect_q.size();
			fails <= mism;
		end
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int LIMIT = 500000;
	localparam int ITEMS_PER_PHASE = 100;

	logic        clk;
	logic        arst_n;
	logic        src_valid;
	logic        src_stall;
	logic [7:0]  ch;
	logic        end_of_text;
	logic        tok_valid;
	logic        tok_stall = 1'b0;
	logic [5:0]  token_kind;
	logic [31:0] start_offset;
	logic [31:0] text_length;
	logic        last;
	int          fails;
	int          outstanding;
	int          cycle_count = 0;
	int          idle_pct = 0;
	int          stall_left = 0;
	int          produced;
	logic [8:0]  text_q[$];

	source_text_tokenizer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_valid    (src_valid),
		.src_stall    (src_stall),
		.ch           (ch),
		.end_of_text  (end_of_text),
		.tok_valid    (tok_valid),
		.tok_stall    (tok_stall),
		.token_kind   (token_kind),
		.start_offset (start_offset),
		.text_length  (text_length),
		.last         (last)
	);

	tb_token_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_valid    (src_valid),
		.src_stall    (src_stall),
		.ch           (ch),
		.end_of_text  (end_of_text),
		.tok_valid    (tok_valid),
		.tok_stall    (tok_stall),
		.token_kind   (token_kind),
		.start_offset (start_offset),
		.text_length  (text_length),
		.last         (last),
		.fails        (fails),
		.outstanding  (outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("source_text_tokenizer_top verification failed");
			$finish;
		end
	end

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
	endfunction

	// token receiver back-pressure
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			tok_stall <= 1'b1;
		end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			stall_left <= gap_len() - 1;
			tok_stall <= 1'b1;
		end else begin
			tok_stall <= 1'b0;
		end
	end

	function automatic logic [7:0] word_byte(input bit first);
		int r;
		r = $urandom_range(0, first ? 52 : 62);
		if (r < 26) return 8'(r) + "a";
		if (r < 52) return 8'(r - 26) + "A";
		if (r == 52) return "_";
		return 8'(r - 53) + "0";
	endfunction

	function automatic logic [7:0] blank_byte();
		int r;
		r = $urandom_range(0, 5);
		return (r < 5) ? 8'(9 + r) : 8'd32;
	endfunction

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_q.insert(text_q.size(), {1'b0, s[i]});
	endtask

	task automatic push_byte(input logic [7:0] c);
		text_q.insert(text_q.size(), {1'b0, c});
	endtask

	task automatic push_eot();
		text_q.insert(text_q.size(), {1'b1, 8'($urandom_range(0, 255))});
	endtask

	task automatic push_digits(input int n);
		for (int i = 0; i < n; i++)
			push_byte(8'($urandom_range(0, 9)) + "0");
	endtask

	task automatic add_piece();
		int         pick;
		int         n0;
		logic [7:0] c;
		n0 = text_q.size();
		pick = $urandom_range(0, 19);
		if (pick < 4) begin
			case ($urandom_range(0, 8))
				0: push_str("int");
				1: push_str("float");
				2: push_str("if");
				3: push_str("else");
				4: push_str("for");
				5: push_str("while");
				6: push_str("cout");
				7: push_str("endl");
				default: push_str("main");
			endcase
			if ($urandom_range(0, 3) == 0) push_byte(word_byte(1'b0));
		end else if (pick < 7) begin
			push_byte(word_byte(1'b1));
			repeat ($urandom_range(0, 7)) push_byte(word_byte(1'b0));
		end else if (pick < 10) begin
			push_digits($urandom_range(1, 4));
			if ($urandom_range(0, 1) == 0) begin
				push_byte(".");
				push_digits($urandom_range(0, 3));
				if ($urandom_range(0, 5) == 0) begin
					push_byte(".");
					push_digits($urandom_range(0, 2));
				end
			end
		end else if (pick < 12) begin
			push_byte("\"");
			repeat ($urandom_range(0, 6)) begin
				c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
					: 8'($urandom_range(32, 126));
				push_byte((c == "\"") ? "q" : c);
			end
			if ($urandom_range(0, 6) != 0) push_byte("\"");
		end else if (pick == 12) begin
			push_str("//");
			repeat ($urandom_range(0, 5)) begin
				c = 8'($urandom_range(0, 255));
				push_byte((c == "\n") ? "c" : c);
			end
			push_byte("\n");
		end else if (pick < 17) begin
			case ($urandom_range(0, 19))
				0:  push_str("==");
				1:  push_str("++");
				2:  push_str("<<");
				3:  push_str("<=");
				4:  push_str(">=");
				5:  push_str("!=");
				6:  push_str("=");
				7:  push_str("+");
				8:  push_str("<");
				9:  push_str(">");
				10: push_str("!");
				11: push_str("/");
				12: push_str("-");
				13: push_str("*");
				14: push_str("%");
				15: push_str("(");
				16: push_str(")");
				17: push_str("{");
				18: push_str("}");
				default: push_str(";");
			endcase
		end else if (pick == 17) begin
			push_byte(8'($urandom_range(0, 255)));
		end else if (pick == 18) begin
			push_eot();
		end else begin
			push_byte(blank_byte());
		end
		if ($urandom_range(0, 1) == 0) push_byte(blank_byte());
		produced += text_q.size() - n0;
	endtask

	task automatic send_item(input logic [7:0] c, input logic eot);
		src_valid <= 1'b1;
		ch <= c;
		end_of_text <= eot;
		@(posedge clk);
		while (src_stall) @(posedge clk);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			src_valid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
	endtask

	task automatic send_text();
		logic [8:0] item;
		while (text_q.size() != 0) begin
			item = text_q.pop_front();
			send_item(item[7:0], item[8]);
		end
	endtask

	task automatic drain();
		src_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin
		int pct [4];
		pct = '{0, 25, 60, 10};
		arst_n = 1'b0;
		src_valid = 1'b0;
		ch = 8'd0;
		end_of_text = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// byte extremes, second point, lone bang, long word, open string,
		// open comment and pending operator at end of text
		push_byte(8'h00);
		push_byte(8'hff);
		push_str("1.2.!=! ");
		push_str("floatx\"ab");
		push_eot();
		push_str("//c");
		push_eot();
		push_str("<");
		push_eot();
		send_text();

		for (int phase = 0; phase < 4; phase++) begin
			drain();
			idle_pct <= pct[phase];
			produced = 0;
			while (produced < ITEMS_PER_PHASE) begin
				add_piece();
				send_text();
			end
		end
		push_eot();
		send_text();
		drain();
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("source_text_tokenizer_top verification clean");
		else
			$display("source_text_tokenizer_top verification failed");
		$finish;
	end

endmodule
